// ===== rtl/cete_pkg.sv =====
// Package for the capped event table: request and status codes, port layout.
// Depends on nothing; used by capped_event_table_evict_oldest_top.
`timescale 1ns / 1ps

package cete_pkg;

    // Request kinds carried in s_tuser
    localparam logic REQ_UPSERT = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    // Result status carried in m_tuser
    typedef logic [2:0] status_t;
    localparam status_t STATUS_UPDATED    = 3'd0;
    localparam status_t STATUS_APPENDED   = 3'd1;
    localparam status_t STATUS_EVICTED    = 3'd2;
    localparam status_t STATUS_READ_OK    = 3'd3;
    localparam status_t STATUS_READ_EMPTY = 3'd4;

    // Fixed field widths
    localparam int ID_W        = 32;
    localparam int PAY_PORT_W  = 64;
    localparam int SLOT_W      = 4;
    localparam int COUNT_W     = 5;
    localparam int CFG_W       = 5;

    // Stream data widths, padded to whole bytes
    localparam int S_TDATA_W   = 104;
    localparam int M_TDATA_W   = 112;

    // Input tdata field offsets
    localparam int S_ID_LSB    = 0;
    localparam int S_PAY_LSB   = 32;
    localparam int S_SLOT_LSB  = 96;

endpackage

// ===== rtl/capped_event_table_evict_oldest_top.sv =====
// Capped event table top level: id and payload memories with a sequencer.
// Depends on cete_pkg for request codes, status codes and port layout.
`timescale 1ns / 1ps

// Keeps a packed table of up to DEPTH entries (signed 32-bit id plus payload)
// in two one-port-read, one-port-write memories with registered reads. One
// request is worked on at a time, and a new request is taken the cycle after
// the previous result is loaded into the output register. A read request for
// a slot below the stored count takes a memory read, while one at or above
// the stored count gets an empty result with no read. An upsert scans the
// stored ids one slot per cycle through the id memory read port, then does an
// update, an append or one eviction and append; an upsert into an empty table
// appends without a scan. Each eviction beyond the first adds another scan of
// the remaining stored entries. The cap register (max_entries) is taken at
// any time on the cfg channel and should be written only while the block is
// idle; 0 acts as 1 and values above DEPTH act as DEPTH. The result sits in an
// output register, so the next request is accepted while a result waits.
// Memory contents are undefined after reset; only slots below the stored
// count are ever read.
module capped_event_table_evict_oldest_top #(
    parameter int DEPTH        = 16,
    parameter int PAYLOAD_BITS = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration: max_entries[4:0]
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cete_pkg::CFG_W-1:0]      cfg_data,
    // requests
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata: entry_id[31:0], entry_payload[95:32], read_slot[99:96], zero pad
    input  logic [cete_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser: req_type[0]
    input  logic                            s_tuser,
    // results
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata: slot_index[3:0], evicted_count[8:4], entry_count[13:9],
    //          out_id[45:14], out_payload[109:46], zero pad
    output logic [cete_pkg::M_TDATA_W-1:0]  m_tdata,
    // m_tuser: status[2:0]
    output logic [2:0]                      m_tuser
);

    localparam int IW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW     = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CW > cete_pkg::CFG_W) ? CW : cete_pkg::CFG_W;
    localparam int RD_W   = (CW > cete_pkg::SLOT_W) ? CW : cete_pkg::SLOT_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_MOVE   = 3'd3;
    localparam logic [2:0] ST_APPEND = 3'd4;
    localparam logic [2:0] ST_RDWAIT = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    // Table storage
    logic [cete_pkg::ID_W-1:0] id_mem  [DEPTH];
    logic [PAYLOAD_BITS-1:0]   pay_mem [DEPTH];

    // Memory port signals
    logic                      rd_en;
    logic [IW-1:0]             rd_addr;
    logic [cete_pkg::ID_W-1:0] rd_id_reg;
    logic [PAYLOAD_BITS-1:0]   rd_pay_reg;
    logic                      id_we;
    logic                      pay_we;
    logic [IW-1:0]             wr_addr;
    logic [cete_pkg::ID_W-1:0] wr_id;
    logic [PAYLOAD_BITS-1:0]   wr_pay;

    // Control state
    logic [2:0]                state_reg, state_next;
    logic [CW-1:0]             count_reg, count_next;
    logic [cete_pkg::CFG_W-1:0] max_entries_reg;
    logic [CW-1:0]             issue_cnt_reg, issue_cnt_next;
    logic                      data_vld_reg, data_vld_next;
    logic                      m_tvalid_reg, m_tvalid_next;

    // Per-request working registers
    logic [IW-1:0]             data_idx_reg, data_idx_next;
    logic                      first_reg, first_next;
    logic                      found_reg, found_next;
    logic [IW-1:0]             match_idx_reg, match_idx_next;
    logic [IW-1:0]             min_idx_reg, min_idx_next;
    logic [cete_pkg::ID_W-1:0] min_id_reg, min_id_next;
    logic [CW-1:0]             evicted_reg, evicted_next;
    logic [cete_pkg::ID_W-1:0] req_id_reg, req_id_next;
    logic [PAYLOAD_BITS-1:0]   req_pay_reg, req_pay_next;
    cete_pkg::status_t         res_status_reg, res_status_next;
    logic [cete_pkg::SLOT_W-1:0] res_slot_reg, res_slot_next;
    logic [cete_pkg::ID_W-1:0] res_id_reg, res_id_next;
    logic [PAYLOAD_BITS-1:0]   res_pay_reg, res_pay_next;
    logic [cete_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    cete_pkg::status_t         m_tuser_reg, m_tuser_next;

    // Derived values
    logic [CMP_W-1:0]          cap_eff;
    logic                      s_accept;
    logic [cete_pkg::SLOT_W-1:0] s_slot;
    logic                      scan_issue;
    logic [CW-1:0]             count_dec;
    logic [CW-1:0]             last_slot;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign s_slot    = s_tdata[cete_pkg::S_SLOT_LSB +: cete_pkg::SLOT_W];
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;
    assign count_dec = count_reg - CW'(1);
    assign last_slot = count_dec;
    assign scan_issue = (issue_cnt_reg < count_reg);

    // Clamp the cap into 1..DEPTH
    always_comb begin
        if (max_entries_reg == '0) begin
            cap_eff = CMP_W'(1);
        end else if (CMP_W'(max_entries_reg) > CMP_W'(DEPTH)) begin
            cap_eff = CMP_W'(DEPTH);
        end else begin
            cap_eff = CMP_W'(max_entries_reg);
        end
    end

    // Sequencer: scan, update, evict, append, read
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        issue_cnt_next  = issue_cnt_reg;
        data_vld_next   = 1'b0;
        data_idx_next   = data_idx_reg;
        first_next      = first_reg;
        found_next      = found_reg;
        match_idx_next  = match_idx_reg;
        min_idx_next    = min_idx_reg;
        min_id_next     = min_id_reg;
        evicted_next    = evicted_reg;
        req_id_next     = req_id_reg;
        req_pay_next    = req_pay_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_id_next     = res_id_reg;
        res_pay_next    = res_pay_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        id_we           = 1'b0;
        pay_we          = 1'b0;
        wr_addr         = '0;
        wr_id           = req_id_reg;
        wr_pay          = req_pay_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    req_id_next    = s_tdata[cete_pkg::S_ID_LSB +: cete_pkg::ID_W];
                    req_pay_next   = s_tdata[cete_pkg::S_PAY_LSB +: PAYLOAD_BITS];
                    res_id_next    = '0;
                    res_pay_next   = '0;
                    evicted_next   = '0;
                    first_next     = 1'b1;
                    found_next     = 1'b0;
                    issue_cnt_next = '0;
                    if (s_tuser == cete_pkg::REQ_READ) begin
                        res_slot_next = s_slot;
                        if (RD_W'(s_slot) < RD_W'(count_reg)) begin
                            rd_en           = 1'b1;
                            rd_addr         = IW'(s_slot);
                            res_status_next = cete_pkg::STATUS_READ_OK;
                            state_next      = ST_RDWAIT;
                        end else begin
                            res_status_next = cete_pkg::STATUS_READ_EMPTY;
                            state_next      = ST_DONE;
                        end
                    end else if (count_reg == '0) begin
                        state_next = ST_APPEND;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN: begin
                // Issue one slot read a cycle, compare the slot read last cycle
                if (scan_issue) begin
                    rd_en          = 1'b1;
                    rd_addr        = issue_cnt_reg[IW-1:0];
                    issue_cnt_next = issue_cnt_reg + CW'(1);
                end
                data_vld_next = scan_issue;
                data_idx_next = issue_cnt_reg[IW-1:0];
                if (data_vld_reg) begin
                    if (first_reg && !found_reg && (rd_id_reg == req_id_reg)) begin
                        found_next     = 1'b1;
                        match_idx_next = data_idx_reg;
                    end
                    if ((data_idx_reg == '0) ||
                        ($signed(rd_id_reg) < $signed(min_id_reg))) begin
                        min_id_next  = rd_id_reg;
                        min_idx_next = data_idx_reg;
                    end
                    if (!scan_issue) begin
                        state_next = ST_DECIDE;
                    end
                end
            end

            ST_DECIDE: begin
                if (first_reg && found_reg) begin
                    // Overwrite the payload of the matching slot
                    pay_we          = 1'b1;
                    wr_addr         = match_idx_reg;
                    res_status_next = cete_pkg::STATUS_UPDATED;
                    res_slot_next   = cete_pkg::SLOT_W'(match_idx_reg);
                    state_next      = ST_DONE;
                end else if ((CMP_W'(count_reg) >= cap_eff) && (count_reg != '0)) begin
                    // Fetch the last entry to fill the evicted slot
                    rd_en      = 1'b1;
                    rd_addr    = last_slot[IW-1:0];
                    state_next = ST_MOVE;
                end else begin
                    state_next = ST_APPEND;
                end
            end

            ST_MOVE: begin
                id_we          = 1'b1;
                pay_we         = 1'b1;
                wr_addr        = min_idx_reg;
                wr_id          = rd_id_reg;
                wr_pay         = rd_pay_reg;
                count_next     = count_dec;
                evicted_next   = evicted_reg + CW'(1);
                first_next     = 1'b0;
                issue_cnt_next = '0;
                if ((CMP_W'(count_dec) >= cap_eff) && (count_dec != '0)) begin
                    state_next = ST_SCAN;
                end else begin
                    state_next = ST_APPEND;
                end
            end

            ST_APPEND: begin
                id_we           = 1'b1;
                pay_we          = 1'b1;
                wr_addr         = count_reg[IW-1:0];
                count_next      = count_reg + CW'(1);
                res_slot_next   = cete_pkg::SLOT_W'(count_reg);
                res_status_next = (evicted_reg != '0) ? cete_pkg::STATUS_EVICTED
                                                      : cete_pkg::STATUS_APPENDED;
                state_next      = ST_DONE;
            end

            ST_RDWAIT: begin
                res_id_next  = rd_id_reg;
                res_pay_next = rd_pay_reg;
                state_next   = ST_DONE;
            end

            ST_DONE: begin
                // Hand the result over once the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_status_reg;
                    m_tdata_next  = {2'b00,
                                     cete_pkg::PAY_PORT_W'(res_pay_reg),
                                     res_id_reg,
                                     cete_pkg::COUNT_W'(count_reg),
                                     cete_pkg::COUNT_W'(evicted_reg),
                                     res_slot_reg};
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Table memories: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (id_we) begin
            id_mem[wr_addr] <= wr_id;
        end
        if (pay_we) begin
            pay_mem[wr_addr] <= wr_pay;
        end
        if (rd_en) begin
            rd_id_reg  <= id_mem[rd_addr];
            rd_pay_reg <= pay_mem[rd_addr];
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            count_reg       <= '0;
            max_entries_reg <= cete_pkg::CFG_W'(16);
            issue_cnt_reg   <= '0;
            data_vld_reg    <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            issue_cnt_reg <= issue_cnt_next;
            data_vld_reg  <= data_vld_next;
            m_tvalid_reg  <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                max_entries_reg <= cfg_data;
            end
        end
    end

    // Working and result registers
    always_ff @(posedge aclk) begin
        data_idx_reg   <= data_idx_next;
        first_reg      <= first_next;
        found_reg      <= found_next;
        match_idx_reg  <= match_idx_next;
        min_idx_reg    <= min_idx_next;
        min_id_reg     <= min_id_next;
        evicted_reg    <= evicted_next;
        req_id_reg     <= req_id_next;
        req_pay_reg    <= req_pay_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_id_reg     <= res_id_next;
        res_pay_reg    <= res_pay_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    // Stored count stays within the table
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        CW'(count_reg) <= CW'(DEPTH))
        else $error("stored count exceeds table depth");

    // No read and write of the same entry in one cycle
    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(rd_en && (id_we || pay_we) && (rd_addr == wr_addr)))
        else $error("read and write of the same entry overlap");

    // An append grows the table by one
    a_append_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_APPEND) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("append did not advance the stored count");

    // An in-place update never reports evictions
    a_update_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && res_status_reg == cete_pkg::STATUS_UPDATED)
        |-> (evicted_reg == '0))
        else $error("update reported evictions");

    // Eviction only runs while the table is at or above the cap
    a_evict_at_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MOVE) |-> (CMP_W'(count_reg) >= cap_eff))
        else $error("eviction below the cap");

endmodule
